/* sv/tcmp_pkg.sv */
// Shared types and constants for the TLS certificate message parser.
// No dependencies; every other file refers to this package by scoped names.

package tcmp_pkg;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_CTXLEN  = 8'b0000_0001,
        PH_CTX     = 8'b0000_0010,
        PH_LISTLEN = 8'b0000_0100,
        PH_CERTLEN = 8'b0000_1000,
        PH_CERT    = 8'b0001_0000,
        PH_EXTLEN  = 8'b0010_0000,
        PH_EXT     = 8'b0100_0000,
        PH_END     = 8'b1000_0000
    } tcmp_phase_t;

    // Byte role codes reported with each result
    localparam logic [2:0] ROLE_CTXLEN  = 3'd0;
    localparam logic [2:0] ROLE_CTX     = 3'd1;
    localparam logic [2:0] ROLE_LISTLEN = 3'd2;
    localparam logic [2:0] ROLE_CERTLEN = 3'd3;
    localparam logic [2:0] ROLE_CERT    = 3'd4;
    localparam logic [2:0] ROLE_EXTLEN  = 3'd5;
    localparam logic [2:0] ROLE_EXT     = 3'd6;
    localparam logic [2:0] ROLE_IGNORED = 3'd7;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONTEXT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CERT_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXT_LEN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES     = 2'd3;
    localparam int unsigned CFG_DATA_W = 24;

    // Length field sizes in bytes
    localparam logic [1:0] LEN24_BYTES = 2'd3;
    localparam logic [1:0] LEN16_BYTES = 2'd2;

    typedef struct packed {
        logic [7:0]  max_context_len;
        logic [23:0] max_cert_len;
        logic [15:0] max_ext_len;
        logic [7:0]  max_entries;
    } tcmp_limits_t;

    typedef struct packed {
        tcmp_phase_t phase;
        logic [1:0]  length_byte_count;
        logic [23:0] length_accumulator;
        logic [23:0] field_remaining;
        logic [23:0] list_remaining;
        logic [7:0]  entry_count;
        logic        error_flag;
    } tcmp_state_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  entry_index;
        logic [23:0] field_value;
        logic        length_done;
        logic        entry_done;
        logic        message_done;
        logic        status;
    } tcmp_result_t;

    localparam tcmp_state_t STATE_RESET = '{
        phase:              PH_CTXLEN,
        length_byte_count:  2'd0,
        length_accumulator: 24'd0,
        field_remaining:    24'd0,
        list_remaining:     24'd0,
        entry_count:        8'd0,
        error_flag:         1'b0
    };

    // Map a phase to the role code of the byte parsed in it
    function automatic logic [2:0] phase_role(input tcmp_phase_t ph);
        logic [2:0] r;
        r = ROLE_IGNORED;
        unique case (ph)
            PH_CTXLEN:  r = ROLE_CTXLEN;
            PH_CTX:     r = ROLE_CTX;
            PH_LISTLEN: r = ROLE_LISTLEN;
            PH_CERTLEN: r = ROLE_CERTLEN;
            PH_CERT:    r = ROLE_CERT;
            PH_EXTLEN:  r = ROLE_EXTLEN;
            PH_EXT:     r = ROLE_EXT;
            default:    r = ROLE_IGNORED;
        endcase
        return r;
    endfunction

endpackage

/* sv/tcmp_if.sv */
// Valid/ready channel interfaces: message bytes in, per-byte results out,
// and configuration register writes. Depends on tcmp_pkg for widths.

interface tcmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tcmp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [7:0]  entry_index;
    logic [23:0] field_value;
    logic        length_done;
    logic        entry_done;
    logic        message_done;
    logic        status;

    modport source (output valid, output byte_role, output entry_index,
                    output field_value, output length_done, output entry_done,
                    output message_done, output status, input ready);
    modport sink   (input valid, input byte_role, input entry_index,
                    input field_value, input length_done, input entry_done,
                    input message_done, input status, output ready);
endinterface

interface tcmp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tcmp_pkg::CFG_IDX_W-1:0]      index;
    logic [tcmp_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/tcmp_cfg_regs.sv */
// Limit registers written through the configuration channel.
// Depends on tcmp_pkg and tcmp_cfg_if.

module tcmp_cfg_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    tcmp_cfg_if.sink                cfg,
    output tcmp_pkg::tcmp_limits_t  limits
);

    tcmp_pkg::tcmp_limits_t limits_reg;

    // Always able to take a write request
    assign cfg.ready = 1'b1;
    assign limits    = limits_reg;

    // Decode the register index and update the addressed limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_context_len <= 8'd255;
            limits_reg.max_cert_len    <= 24'd16384;
            limits_reg.max_ext_len     <= 16'd4096;
            limits_reg.max_entries     <= 8'd8;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tcmp_pkg::CFG_MAX_CONTEXT_LEN: limits_reg.max_context_len <= cfg.data[7:0];
                tcmp_pkg::CFG_MAX_CERT_LEN:    limits_reg.max_cert_len    <= cfg.data[23:0];
                tcmp_pkg::CFG_MAX_EXT_LEN:     limits_reg.max_ext_len     <= cfg.data[15:0];
                tcmp_pkg::CFG_MAX_ENTRIES:     limits_reg.max_entries     <= cfg.data[7:0];
                default:                       limits_reg <= limits_reg;
            endcase
        end
    end

endmodule

/* sv/tcmp_parse_step.sv */
// Next-state and result logic for one message byte.
// Depends on tcmp_pkg.

module tcmp_parse_step (
    input  tcmp_pkg::tcmp_state_t   cur,
    input  tcmp_pkg::tcmp_limits_t  limits,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    output tcmp_pkg::tcmp_state_t   nxt,
    output tcmp_pkg::tcmp_result_t  res
);

    logic        in_list;
    logic [23:0] acc_shift;
    logic [1:0]  cnt_inc;
    logic [1:0]  cnt_target;
    logic        len_complete;

    assign in_list = (cur.phase == tcmp_pkg::PH_CERTLEN) || (cur.phase == tcmp_pkg::PH_CERT)
                  || (cur.phase == tcmp_pkg::PH_EXTLEN) || (cur.phase == tcmp_pkg::PH_EXT);
    assign acc_shift    = {cur.length_accumulator[15:0], data_byte};
    assign cnt_inc      = cur.length_byte_count + 2'd1;
    assign cnt_target   = (cur.phase == tcmp_pkg::PH_EXTLEN) ? tcmp_pkg::LEN16_BYTES
                                                             : tcmp_pkg::LEN24_BYTES;
    assign len_complete = (cnt_inc == cnt_target);

    always_comb
    begin
        nxt                  = cur;
        res.byte_role        = tcmp_pkg::ROLE_IGNORED;
        res.entry_index      = cur.entry_count;
        res.field_value      = 24'd0;
        res.length_done      = 1'b0;
        res.entry_done       = 1'b0;
        res.message_done     = last_byte;
        res.status           = 1'b0;

        if (cur.error_flag)
        begin
            // Drop bytes once an error is latched
            res.byte_role = tcmp_pkg::ROLE_IGNORED;
        end
        else if ((cur.phase == tcmp_pkg::PH_END) || (in_list && cur.list_remaining == 24'd0))
        begin
            // Byte past the end of the list
            nxt.error_flag = 1'b1;
        end
        else
        begin
            res.byte_role = tcmp_pkg::phase_role(cur.phase);
            if (in_list)
            begin
                nxt.list_remaining = cur.list_remaining - 24'd1;
            end
            unique case (cur.phase)
                tcmp_pkg::PH_CTXLEN:
                begin
                    res.length_done        = 1'b1;
                    res.field_value        = {16'd0, data_byte};
                    nxt.error_flag         = (data_byte > limits.max_context_len);
                    nxt.field_remaining    = {16'd0, data_byte};
                    nxt.phase              = (data_byte == 8'd0) ? tcmp_pkg::PH_LISTLEN
                                                                 : tcmp_pkg::PH_CTX;
                    nxt.length_byte_count  = 2'd0;
                    nxt.length_accumulator = 24'd0;
                end
                tcmp_pkg::PH_CTX, tcmp_pkg::PH_CERT:
                begin
                    nxt.field_remaining = cur.field_remaining - 24'd1;
                    if (cur.field_remaining == 24'd1)
                    begin
                        nxt.phase = (cur.phase == tcmp_pkg::PH_CTX) ? tcmp_pkg::PH_LISTLEN
                                                                    : tcmp_pkg::PH_EXTLEN;
                    end
                end
                tcmp_pkg::PH_LISTLEN, tcmp_pkg::PH_CERTLEN, tcmp_pkg::PH_EXTLEN:
                begin
                    if (cur.phase == tcmp_pkg::PH_CERTLEN && cur.length_byte_count == 2'd0
                        && cur.entry_count >= limits.max_entries)
                    begin
                        nxt.error_flag = 1'b1;
                    end
                    else if (!len_complete)
                    begin
                        // Gather another length byte
                        nxt.length_accumulator = acc_shift;
                        nxt.length_byte_count  = cnt_inc;
                    end
                    else
                    begin
                        res.length_done        = 1'b1;
                        res.field_value        = acc_shift;
                        nxt.length_byte_count  = 2'd0;
                        nxt.length_accumulator = 24'd0;
                        if (cur.phase == tcmp_pkg::PH_LISTLEN)
                        begin
                            nxt.list_remaining = acc_shift;
                            nxt.phase = (acc_shift == 24'd0) ? tcmp_pkg::PH_END
                                                             : tcmp_pkg::PH_CERTLEN;
                        end
                        else if (cur.phase == tcmp_pkg::PH_CERTLEN)
                        begin
                            nxt.error_flag      = (acc_shift == 24'd0)
                                               || (acc_shift > limits.max_cert_len);
                            nxt.field_remaining = acc_shift;
                            nxt.phase           = tcmp_pkg::PH_CERT;
                        end
                        else
                        begin
                            nxt.error_flag      = (acc_shift > {8'd0, limits.max_ext_len});
                            nxt.field_remaining = acc_shift;
                            if (acc_shift == 24'd0)
                            begin
                                res.entry_done  = 1'b1;
                                nxt.entry_count = cur.entry_count + 8'd1;
                                nxt.phase = (nxt.list_remaining == 24'd0) ? tcmp_pkg::PH_END
                                                                          : tcmp_pkg::PH_CERTLEN;
                            end
                            else
                            begin
                                nxt.phase = tcmp_pkg::PH_EXT;
                            end
                        end
                    end
                end
                tcmp_pkg::PH_EXT:
                begin
                    nxt.field_remaining = cur.field_remaining - 24'd1;
                    if (cur.field_remaining == 24'd1)
                    begin
                        res.entry_done  = 1'b1;
                        nxt.entry_count = cur.entry_count + 8'd1;
                        nxt.phase = (nxt.list_remaining == 24'd0) ? tcmp_pkg::PH_END
                                                                  : tcmp_pkg::PH_CERTLEN;
                    end
                end
                default:
                begin
                    nxt.error_flag = 1'b1;
                end
            endcase
            // Suppress entry completion on an erroneous byte
            if (nxt.error_flag)
            begin
                res.entry_done = 1'b0;
            end
        end

        // Check the message ends exactly at the list end, then restart
        if (last_byte && nxt.phase != tcmp_pkg::PH_END)
        begin
            nxt.error_flag = 1'b1;
        end
        res.status = nxt.error_flag;
        if (last_byte)
        begin
            nxt = tcmp_pkg::STATE_RESET;
        end
    end

endmodule

/* sv/tls_certificate_message_parser.sv */
// TLS 1.3 Certificate message parser, one byte per request.
// Each accepted byte's result is captured in the output register in the cycle after it is accepted.
// Throughput: one byte per cycle while the sink keeps up; the parse step is combinational.
// The output register holds a result while the sink stalls; a new byte is taken
// whenever that register is empty or being read in the same cycle.
// Reset (rst_n low, asynchronous) restores the parse state and limit registers.

module tls_certificate_message_parser (
    input  logic         clk,
    input  logic         rst_n,
    tcmp_byte_if.sink    src,
    tcmp_result_if.source dst,
    tcmp_cfg_if.sink     cfg
);

    tcmp_pkg::tcmp_limits_t limits;
    tcmp_pkg::tcmp_state_t  state_reg;
    tcmp_pkg::tcmp_state_t  state_next;
    tcmp_pkg::tcmp_result_t result_next;
    tcmp_pkg::tcmp_result_t result_reg;
    logic                   out_valid_reg;
    logic                   accept;

    tcmp_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    tcmp_parse_step u_parse_step (
        .cur       (state_reg),
        .limits    (limits),
        .data_byte (src.data_byte),
        .last_byte (src.last_byte),
        .nxt       (state_next),
        .res       (result_next)
    );

    assign src.ready = !out_valid_reg || dst.ready;
    assign accept    = src.valid && src.ready;

    // Advance the parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcmp_pkg::STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dst.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign dst.valid        = out_valid_reg;
    assign dst.byte_role    = result_reg.byte_role;
    assign dst.entry_index  = result_reg.entry_index;
    assign dst.field_value  = result_reg.field_value;
    assign dst.length_done  = result_reg.length_done;
    assign dst.entry_done   = result_reg.entry_done;
    assign dst.message_done = result_reg.message_done;
    assign dst.status       = result_reg.status;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the TLS certificate message parser.
// Depends on tcmp_pkg and the channel interfaces in tcmp_if.sv; drives byte
// requests and limit writes, predicts every result and compares field by field.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned ITEMS_PER_SETTING = 270;

    typedef struct {
        logic [7:0]  value;
        logic        last;
        int unsigned gap;
    } msg_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    tcmp_byte_if   byte_ch();
    tcmp_result_if res_ch();
    tcmp_cfg_if    cfg_ch();

    tls_certificate_message_parser u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (byte_ch),
        .dst   (res_ch),
        .cfg   (cfg_ch)
    );

    // Parser state as seen by the prediction
    tcmp_pkg::tcmp_limits_t limits;
    tcmp_pkg::tcmp_phase_t  cur_phase;
    logic [1:0]   len_bytes;
    logic [23:0]  len_acc;
    logic [23:0]  field_left;
    logic [23:0]  list_left;
    logic [7:0]   entries_seen;
    logic         parse_err;

    msg_byte_t              pending_bytes[$];
    tcmp_pkg::tcmp_result_t byte_reports_due[$];
    logic [7:0]             msg_bytes[$];

    msg_byte_t    next_byte;
    bit           have_next;
    bit           calm;
    int unsigned  stall_left;
    int unsigned  idle_cycles;
    int unsigned  fail_count;
    int unsigned  reports_checked;
    int unsigned  messages_clean;
    int unsigned  messages_sent;
    int unsigned  items_queued;
    int unsigned  bytes_accepted;
    int unsigned  settings_used;
    tcmp_pkg::tcmp_result_t want;

    always #5ns clk = ~clk;

    // Return the parse state to the start of a message
    function automatic void clear_parse();
        cur_phase    = tcmp_pkg::PH_CTXLEN;
        len_bytes    = 2'd0;
        len_acc      = 24'd0;
        field_left   = 24'd0;
        list_left    = 24'd0;
        entries_seen = 8'd0;
        parse_err    = 1'b0;
    endfunction

    // Count a finished entry and pick the next phase
    function automatic void close_entry();
        entries_seen = entries_seen + 8'd1;
        cur_phase = (list_left == 24'd0) ? tcmp_pkg::PH_END : tcmp_pkg::PH_CERTLEN;
    endfunction

    // Advance the parse by one byte and return the report it should produce
    function automatic tcmp_pkg::tcmp_result_t parse_byte(input logic [7:0] b,
                                                          input logic last);
        tcmp_pkg::tcmp_result_t r;
        logic         in_list;
        logic [1:0]   width;
        logic [23:0]  field_len;
        r = '0;
        r.byte_role    = tcmp_pkg::ROLE_IGNORED;
        r.entry_index  = entries_seen;
        r.message_done = last;
        in_list = (cur_phase == tcmp_pkg::PH_CERTLEN) || (cur_phase == tcmp_pkg::PH_CERT) ||
                  (cur_phase == tcmp_pkg::PH_EXTLEN) || (cur_phase == tcmp_pkg::PH_EXT);
        if (!parse_err) begin
            if (cur_phase == tcmp_pkg::PH_END || (in_list && list_left == 24'd0)) begin
                // overrun past the list end
                parse_err = 1'b1;
            end
            else begin
                if (in_list)
                    list_left = list_left - 24'd1;
                case (cur_phase)
                    tcmp_pkg::PH_CTXLEN:
                    begin
                        r.byte_role   = tcmp_pkg::ROLE_CTXLEN;
                        r.length_done = 1'b1;
                        r.field_value = {16'd0, b};
                        if (b > limits.max_context_len)
                            parse_err = 1'b1;
                        field_left = {16'd0, b};
                        cur_phase  = (b == 8'd0) ? tcmp_pkg::PH_LISTLEN : tcmp_pkg::PH_CTX;
                        len_bytes  = 2'd0;
                        len_acc    = 24'd0;
                    end
                    tcmp_pkg::PH_CTX:
                    begin
                        r.byte_role = tcmp_pkg::ROLE_CTX;
                        field_left  = field_left - 24'd1;
                        if (field_left == 24'd0)
                            cur_phase = tcmp_pkg::PH_LISTLEN;
                    end
                    tcmp_pkg::PH_LISTLEN, tcmp_pkg::PH_CERTLEN, tcmp_pkg::PH_EXTLEN:
                    begin
                        r.byte_role = (cur_phase == tcmp_pkg::PH_LISTLEN) ?
                                          tcmp_pkg::ROLE_LISTLEN :
                                      (cur_phase == tcmp_pkg::PH_CERTLEN) ?
                                          tcmp_pkg::ROLE_CERTLEN : tcmp_pkg::ROLE_EXTLEN;
                        if (cur_phase == tcmp_pkg::PH_CERTLEN && len_bytes == 2'd0 &&
                            entries_seen >= limits.max_entries) begin
                            parse_err = 1'b1;
                        end
                        else begin
                            len_acc   = {len_acc[15:0], b};
                            len_bytes = len_bytes + 2'd1;
                            width = (cur_phase == tcmp_pkg::PH_EXTLEN) ?
                                        tcmp_pkg::LEN16_BYTES : tcmp_pkg::LEN24_BYTES;
                            if (len_bytes == width) begin
                                r.length_done = 1'b1;
                                r.field_value = len_acc;
                                field_len = len_acc;
                                len_bytes = 2'd0;
                                len_acc   = 24'd0;
                                case (cur_phase)
                                    tcmp_pkg::PH_LISTLEN:
                                    begin
                                        list_left = field_len;
                                        cur_phase = (field_len == 24'd0) ?
                                                        tcmp_pkg::PH_END : tcmp_pkg::PH_CERTLEN;
                                    end
                                    tcmp_pkg::PH_CERTLEN:
                                    begin
                                        if (field_len == 24'd0 ||
                                            field_len > limits.max_cert_len)
                                            parse_err = 1'b1;
                                        field_left = field_len;
                                        cur_phase  = tcmp_pkg::PH_CERT;
                                    end
                                    default:
                                    begin
                                        if (field_len > {8'd0, limits.max_ext_len})
                                            parse_err = 1'b1;
                                        field_left = field_len;
                                        if (field_len == 24'd0) begin
                                            r.entry_done = 1'b1;
                                            close_entry();
                                        end
                                        else begin
                                            cur_phase = tcmp_pkg::PH_EXT;
                                        end
                                    end
                                endcase
                            end
                        end
                    end
                    tcmp_pkg::PH_CERT:
                    begin
                        r.byte_role = tcmp_pkg::ROLE_CERT;
                        field_left  = field_left - 24'd1;
                        if (field_left == 24'd0)
                            cur_phase = tcmp_pkg::PH_EXTLEN;
                    end
                    default:
                    begin
                        r.byte_role = tcmp_pkg::ROLE_EXT;
                        field_left  = field_left - 24'd1;
                        if (field_left == 24'd0) begin
                            r.entry_done = 1'b1;
                            close_entry();
                        end
                    end
                endcase
                if (parse_err)
                    r.entry_done = 1'b0;
            end
        end
        // a message must end exactly at the list end
        if (last && cur_phase != tcmp_pkg::PH_END)
            parse_err = 1'b1;
        r.status = parse_err;
        if (last)
            clear_parse();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Byte driver: present queued requests, honoring each one's idle gap
    always @(posedge clk) begin
        if (!rst_n) begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= 8'd0;
            byte_ch.last_byte <= 1'b0;
            have_next = 1'b0;
        end
        else begin
            if (byte_ch.valid && byte_ch.ready) begin
                byte_reports_due.push_back(parse_byte(byte_ch.data_byte, byte_ch.last_byte));
                bytes_accepted++;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (!have_next && pending_bytes.size() != 0) begin
                    next_byte = pending_bytes.pop_front();
                    have_next = 1'b1;
                end
                if (have_next && next_byte.gap == 0) begin
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= next_byte.value;
                    byte_ch.last_byte <= next_byte.last;
                    have_next = 1'b0;
                end
                else begin
                    byte_ch.valid <= 1'b0;
                    if (have_next)
                        next_byte.gap--;
                end
            end
        end
    end

    // Result monitor: compare each report with the oldest prediction, then sometimes stall
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b1;
            stall_left = 0;
        end
        else begin
            if (res_ch.valid && res_ch.ready) begin
                if (byte_reports_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual role %0d index %0d value %0h",
                             $time, res_ch.byte_role, res_ch.entry_index, res_ch.field_value);
                    fail_count++;
                end
                else begin
                    want = byte_reports_due.pop_front();
                    check_field("byte_role", 24'(want.byte_role), 24'(res_ch.byte_role));
                    check_field("entry_index", 24'(want.entry_index), 24'(res_ch.entry_index));
                    check_field("field_value", want.field_value, res_ch.field_value);
                    check_field("length_done", 24'(want.length_done), 24'(res_ch.length_done));
                    check_field("entry_done", 24'(want.entry_done), 24'(res_ch.entry_done));
                    check_field("message_done", 24'(want.message_done),
                                24'(res_ch.message_done));
                    check_field("status", 24'(want.status), 24'(res_ch.status));
                    reports_checked++;
                    if (want.message_done && !want.status)
                        messages_clean++;
                end
                stall_left = calm ? 0 : $urandom_range(0, 7);
            end
            if (stall_left != 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no channel moves a request for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, byte_reports_due.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Hold until every queued request is accepted and every result is back
    task automatic wait_idle();
        while (bytes_accepted != items_queued || byte_reports_due.size() != 0)
            @(posedge clk);
    endtask

    // Write one limit register; valid stays high for a following write
    task automatic write_reg(input logic [tcmp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            tcmp_pkg::CFG_MAX_CONTEXT_LEN: limits.max_context_len = val[7:0];
            tcmp_pkg::CFG_MAX_CERT_LEN:    limits.max_cert_len    = val;
            tcmp_pkg::CFG_MAX_EXT_LEN:     limits.max_ext_len     = val[15:0];
            default:                       limits.max_entries     = val[7:0];
        endcase
    endtask

    task automatic apply_limits(input logic [7:0] ctx_max, input logic [23:0] cert_max,
                                input logic [15:0] ext_max, input logic [7:0] ent_max);
        write_reg(tcmp_pkg::CFG_MAX_CONTEXT_LEN, {16'd0, ctx_max});
        write_reg(tcmp_pkg::CFG_MAX_CERT_LEN, cert_max);
        write_reg(tcmp_pkg::CFG_MAX_EXT_LEN, {8'd0, ext_max});
        write_reg(tcmp_pkg::CFG_MAX_ENTRIES, {16'd0, ent_max});
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Queue the assembled message, marking its final byte
    task automatic send_message();
        msg_byte_t item;
        foreach (msg_bytes[i]) begin
            item.value = msg_bytes[i];
            item.last  = (i == msg_bytes.size() - 1);
            item.gap   = calm ? 0 : $urandom_range(0, 7);
            pending_bytes.push_back(item);
        end
        items_queued += msg_bytes.size();
        messages_sent++;
        msg_bytes.delete();
    endtask

    task automatic put_len(input int unsigned value, input int unsigned nbytes);
        for (int k = int'(nbytes) - 1; k >= 0; k--)
            msg_bytes.push_back(8'(value >> (8 * k)));
    endtask

    // Build a message sized around the current limits, sometimes damaged
    task automatic build_chain();
        int unsigned ctx_n, n_ent, list_len, cap, cut, pos, kind;
        int unsigned cert_n[4];
        int unsigned ext_n[4];
        cap = limits.max_context_len + 1;
        ctx_n = $urandom_range(0, (cap > 5) ? 5 : cap);
        if ($urandom_range(0, 19) == 0) begin
            ctx_n = limits.max_context_len + $urandom_range(0, 1);
            if (ctx_n > 255)
                ctx_n = 255;
        end
        cap = limits.max_entries + 1;
        n_ent = $urandom_range(0, (cap > 4) ? 4 : cap);
        list_len = 0;
        for (int i = 0; i < int'(n_ent); i++) begin
            cap = limits.max_cert_len + 1;
            cert_n[i] = $urandom_range(1, (cap > 6) ? 6 : cap);
            if ($urandom_range(0, 11) == 0)
                cert_n[i] = 0;
            cap = limits.max_ext_len + 1;
            ext_n[i] = $urandom_range(0, (cap > 4) ? 4 : cap);
            list_len += 5 + cert_n[i] + ext_n[i];
        end
        msg_bytes.push_back(8'(ctx_n));
        repeat (ctx_n) msg_bytes.push_back(8'($urandom_range(0, 255)));
        put_len(list_len, 3);
        for (int i = 0; i < int'(n_ent); i++) begin
            put_len(cert_n[i], 3);
            repeat (cert_n[i]) msg_bytes.push_back(8'($urandom_range(0, 255)));
            put_len(ext_n[i], 2);
            repeat (ext_n[i]) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        kind = $urandom_range(0, 11);
        case (kind)
            8:
            begin
                // drop the tail so the message ends early
                if (msg_bytes.size() > 1) begin
                    cut = $urandom_range(1, msg_bytes.size() - 1);
                    while (msg_bytes.size() > cut)
                        void'(msg_bytes.pop_back());
                end
            end
            9:  msg_bytes.push_back(8'($urandom_range(0, 255)));
            10: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            11:
            begin
                // scramble the list and first certificate lengths, then cut short
                pos = ctx_n + 1;
                for (int k = 0; k < 3; k++)
                    msg_bytes[pos + k] = 8'($urandom_range(0, 255));
                if (n_ent != 0)
                    for (int k = 3; k < 6; k++)
                        msg_bytes[pos + k] = 8'($urandom_range(0, 255));
                cut = pos + 6 + $urandom_range(0, 4);
                while (msg_bytes.size() > cut)
                    void'(msg_bytes.pop_back());
            end
            default: ;
        endcase
    endtask

    initial begin
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= tcmp_pkg::CFG_MAX_CONTEXT_LEN;
        cfg_ch.data       <= '0;
        limits = '{max_context_len: 8'd255, max_cert_len: 24'd16384,
                   max_ext_len: 16'd4096, max_entries: 8'd8};
        clear_parse();
        calm = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tight limits, then a few hand-built messages
        apply_limits(8'd1, 24'd2, 16'd1, 8'd1);
        // empty list followed by a byte past the list end
        msg_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h7F};
        send_message();
        // one full entry with context and extension at the limits, certificate under its limit
        msg_bytes = '{8'h01, 8'hFF, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 8'h01,
                      8'hAA, 8'h00, 8'h01, 8'h55};
        send_message();
        // second entry beyond the entry limit, flagged on its first length byte
        msg_bytes = '{8'h00, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h00, 8'h01, 8'h80,
                      8'h00, 8'h00, 8'h00};
        send_message();
        // zero certificate length
        msg_bytes = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00};
        send_message();
        wait_idle();

        // Random: sweep several limit settings, draining between them
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: apply_limits(8'd255, 24'hFFFFFF, 16'hFFFF, 8'd255);
                1: apply_limits(8'd0, 24'd1, 16'd0, 8'd0);
                2: apply_limits(8'd3, 24'd4, 16'd2, 8'd3);
                3: apply_limits(8'($urandom_range(0, 255)), 24'($urandom_range(1, 8)),
                                16'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
                default: apply_limits(8'd255, 24'd16384, 16'd4096, 8'd8);
            endcase
            while (items_queued < 40 + (s + 1) * ITEMS_PER_SETTING) begin
                calm = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
                else begin
                    build_chain();
                end
                send_message();
                // now and then let the pipeline run dry before going on
                if ($urandom_range(0, 24) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (byte_reports_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, byte_reports_due.size());
            fail_count++;
        end
        $display("Covered %0d byte results over %0d messages under %0d limit settings;",
                 reports_checked, messages_sent, settings_used);
        $display("%0d messages parsed clean, %0d mismatches seen.", messages_clean, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
